/* rtl/core/sld_pkg.sv */
package sld_pkg;

   localparam int unsigned COORD_W     = 24;
   localparam int unsigned LEN_W       = 25;
   localparam int unsigned DIR_W       = 16;
   localparam int unsigned DIR_FRAC    = 14;
   localparam int unsigned QUOT_W      = DIR_FRAC + 1;
   localparam int unsigned RAD_W       = 2 * LEN_W;
   localparam int unsigned SQRT_STAGES = LEN_W;
   localparam int unsigned DIV_STAGES  = QUOT_W;
   // front stages + root stages + quotient stages + output register
   localparam int unsigned PIPE_LATENCY = 4 + SQRT_STAGES + DIV_STAGES + 1;

   typedef struct packed {
      logic signed [COORD_W-1:0] first_x;
      logic signed [COORD_W-1:0] first_y;
      logic signed [COORD_W-1:0] first_z;
      logic signed [COORD_W-1:0] second_x;
      logic signed [COORD_W-1:0] second_y;
      logic signed [COORD_W-1:0] second_z;
   } sld_req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] start_x;
      logic signed [COORD_W-1:0] start_y;
      logic signed [COORD_W-1:0] end_x;
      logic signed [COORD_W-1:0] end_y;
      logic signed [COORD_W-1:0] mid_z;
      logic        [LEN_W-1:0]   length;
      logic signed [DIR_W-1:0]   dir_x;
      logic signed [DIR_W-1:0]   dir_y;
      logic                      zero_length;
   } sld_rsp_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] start_x;
      logic signed [COORD_W-1:0] start_y;
      logic signed [COORD_W-1:0] end_x;
      logic signed [COORD_W-1:0] end_y;
      logic signed [COORD_W-1:0] mid_z;
      logic                      neg_x;
      logic                      neg_y;
   } sld_side_type;

   typedef struct packed {
      sld_side_type       side;
      logic [COORD_W-1:0] mag_x;
      logic [COORD_W-1:0] mag_y;
   } sld_pre_type;

   typedef struct packed {
      sld_side_type     side;
      logic [LEN_W-1:0] len;
   } sld_post_type;

endpackage

/* rtl/core/sld_sqrt.sv */
module sld_sqrt
   import sld_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [RAD_W-1:0] in_rad,
   output logic             out_valid,
   output logic [LEN_W-1:0] out_root
);

   localparam int unsigned REM_W = LEN_W + 2;

   logic             vld_ff  [SQRT_STAGES];
   logic [RAD_W-1:0] rad_ff  [SQRT_STAGES];
   logic [REM_W-1:0] rem_ff  [SQRT_STAGES];
   logic [LEN_W-1:0] root_ff [SQRT_STAGES];

   logic             vld_tap  [SQRT_STAGES];
   logic [RAD_W-1:0] rad_tap  [SQRT_STAGES];
   logic [REM_W-1:0] rem_tap  [SQRT_STAGES];
   logic [LEN_W-1:0] root_tap [SQRT_STAGES];

   logic [RAD_W-1:0] rad_in  [SQRT_STAGES];
   logic [REM_W-1:0] rem_in  [SQRT_STAGES];
   logic [LEN_W-1:0] root_in [SQRT_STAGES];

   genvar g;
   generate
      for (g = 0; g < SQRT_STAGES; g++) begin : g_tap
         if (g == 0) begin : g_first
            assign vld_tap[g]  = in_valid;
            assign rad_tap[g]  = in_rad;
            assign rem_tap[g]  = '0;
            assign root_tap[g] = '0;
         end else begin : g_next
            assign vld_tap[g]  = vld_ff[g-1];
            assign rad_tap[g]  = rad_ff[g-1];
            assign rem_tap[g]  = rem_ff[g-1];
            assign root_tap[g] = root_ff[g-1];
         end
      end
   endgenerate

   // one root bit per stage: bring down two radicand bits, try 4*root+1
   always_comb begin
      logic [REM_W+1:0] acc;
      logic [REM_W+1:0] trial;
      for (int k = 0; k < SQRT_STAGES; k++) begin
         acc   = {rem_tap[k], rad_tap[k][RAD_W-1 -: 2]};
         trial = {2'b00, root_tap[k], 2'b01};
         rad_in[k] = {rad_tap[k][RAD_W-3:0], 2'b00};
         if (acc >= trial) begin
            rem_in[k]  = REM_W'(acc - trial);
            root_in[k] = {root_tap[k][LEN_W-2:0], 1'b1};
         end else begin
            rem_in[k]  = REM_W'(acc);
            root_in[k] = {root_tap[k][LEN_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < SQRT_STAGES; k++) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_tap[k];
         end
         rad_ff[k]  <= rad_in[k];
         rem_ff[k]  <= rem_in[k];
         root_ff[k] <= root_in[k];
      end
   end

   assign out_valid = vld_ff[SQRT_STAGES-1];
   assign out_root  = root_ff[SQRT_STAGES-1];

endmodule

/* rtl/core/sld_div.sv */
module sld_div
   import sld_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic [COORD_W-1:0] in_mag,
   input  logic [LEN_W-1:0]   in_len,
   output logic               out_valid,
   output logic [QUOT_W-1:0]  out_quot
);

   // quotient of (mag << DIR_FRAC) / len; mag <= len keeps it below 2^QUOT_W
   logic              vld_ff [DIV_STAGES];
   logic [LEN_W-1:0]  rem_ff [DIV_STAGES];
   logic [LEN_W-1:0]  len_ff [DIV_STAGES];
   logic [QUOT_W-1:0] num_ff [DIV_STAGES];
   logic [QUOT_W-1:0] quo_ff [DIV_STAGES];

   logic              vld_tap [DIV_STAGES];
   logic [LEN_W-1:0]  rem_tap [DIV_STAGES];
   logic [LEN_W-1:0]  len_tap [DIV_STAGES];
   logic [QUOT_W-1:0] num_tap [DIV_STAGES];
   logic [QUOT_W-1:0] quo_tap [DIV_STAGES];

   logic [LEN_W-1:0]  rem_in [DIV_STAGES];
   logic [QUOT_W-1:0] num_in [DIV_STAGES];
   logic [QUOT_W-1:0] quo_in [DIV_STAGES];

   genvar g;
   generate
      for (g = 0; g < DIV_STAGES; g++) begin : g_tap
         if (g == 0) begin : g_first
            assign vld_tap[g] = in_valid;
            assign rem_tap[g] = LEN_W'(in_mag >> 1);
            assign len_tap[g] = in_len;
            assign num_tap[g] = {in_mag[0], {(QUOT_W-1){1'b0}}};
            assign quo_tap[g] = '0;
         end else begin : g_next
            assign vld_tap[g] = vld_ff[g-1];
            assign rem_tap[g] = rem_ff[g-1];
            assign len_tap[g] = len_ff[g-1];
            assign num_tap[g] = num_ff[g-1];
            assign quo_tap[g] = quo_ff[g-1];
         end
      end
   endgenerate

   always_comb begin
      logic [LEN_W:0] acc;
      for (int k = 0; k < DIV_STAGES; k++) begin
         acc       = {rem_tap[k], num_tap[k][QUOT_W-1]};
         num_in[k] = {num_tap[k][QUOT_W-2:0], 1'b0};
         if (acc >= {1'b0, len_tap[k]}) begin
            rem_in[k] = LEN_W'(acc - {1'b0, len_tap[k]});
            quo_in[k] = {quo_tap[k][QUOT_W-2:0], 1'b1};
         end else begin
            rem_in[k] = LEN_W'(acc);
            quo_in[k] = {quo_tap[k][QUOT_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_tap[k];
         end
         rem_ff[k] <= rem_in[k];
         len_ff[k] <= len_tap[k];
         num_ff[k] <= num_in[k];
         quo_ff[k] <= quo_in[k];
      end
   end

   assign out_valid = vld_ff[DIV_STAGES-1];
   assign out_quot  = quo_ff[DIV_STAGES-1];

endmodule

/* rtl/core/segment_length_and_direction.sv */
// Segment length and direction. Each transfer on start carries two 3D
// endpoints in signed Q12.12; for each one, a result later appears for a
// single cycle with rsp_valid high: both XY endpoints unchanged, the
// floored mean of the Z values, the floored XY length in unsigned Q13.12
// and the unit direction in signed Q1.14 (truncated toward zero).
// A segment whose endpoints coincide in XY gives zero direction and sets
// zero_length. A new segment is taken every cycle: busy is always low.
// The pipeline is four front stages (difference, magnitude, square, sum),
// 25 square-root stages (one root bit each), 15 divider stages (one
// quotient bit each, x and y in parallel) and one output register. The
// receiver cannot stall, so capture every result in the cycle it is shown.
module segment_length_and_direction
   import sld_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  sld_req_type req_data,
   output logic        rsp_valid,
   output sld_rsp_type rsp_data
);

   // stage 1: differences and Z mean
   logic                    v1_ff;
   sld_side_type            side1_ff, side1_in;
   logic signed [COORD_W:0] ddx1_ff, ddy1_ff;
   logic signed [COORD_W:0] zsum;

   // stage 2: magnitudes
   logic               v2_ff;
   sld_side_type       side2_ff, side2_in;
   logic [COORD_W-1:0] ax2_ff, ay2_ff, ax2_in, ay2_in;

   // stage 3: squares
   logic                 v3_ff;
   sld_pre_type          pre3_ff;
   logic [2*COORD_W-1:0] sqx3_ff, sqy3_ff;

   // stage 4: sum of squares
   logic               v4_ff;
   sld_pre_type        pre4_ff;
   logic [2*COORD_W:0] sum4_ff;

   sld_pre_type      pre_dly_ff [SQRT_STAGES];
   logic             root_valid;
   logic [LEN_W-1:0] root;

   sld_post_type post_dly_ff [DIV_STAGES];
   sld_post_type post_in;
   logic              qx_valid, qy_valid;
   logic [QUOT_W-1:0] qx, qy;

   logic        rsp_valid_ff;
   sld_rsp_type rsp_ff, rsp_in;

   // no back pressure anywhere: every stage advances each cycle
   assign busy = 1'b0;

   always_comb begin
      zsum = {req_data.first_z[COORD_W-1], req_data.first_z}
           + {req_data.second_z[COORD_W-1], req_data.second_z};
      side1_in.start_x = req_data.first_x;
      side1_in.start_y = req_data.first_y;
      side1_in.end_x   = req_data.second_x;
      side1_in.end_y   = req_data.second_y;
      side1_in.mid_z   = zsum[COORD_W:1];   // arithmetic halve, floored
      side1_in.neg_x   = 1'b0;
      side1_in.neg_y   = 1'b0;
   end

   always_comb begin
      side2_in       = side1_ff;
      side2_in.neg_x = ddx1_ff[COORD_W];
      side2_in.neg_y = ddy1_ff[COORD_W];
      ax2_in = ddx1_ff[COORD_W] ? COORD_W'(-ddx1_ff) : COORD_W'(ddx1_ff);
      ay2_in = ddy1_ff[COORD_W] ? COORD_W'(-ddy1_ff) : COORD_W'(ddy1_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= start & ~busy;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
      side1_ff <= side1_in;
      ddx1_ff  <= {req_data.second_x[COORD_W-1], req_data.second_x}
                - {req_data.first_x[COORD_W-1], req_data.first_x};
      ddy1_ff  <= {req_data.second_y[COORD_W-1], req_data.second_y}
                - {req_data.first_y[COORD_W-1], req_data.first_y};
      side2_ff <= side2_in;
      ax2_ff   <= ax2_in;
      ay2_ff   <= ay2_in;
      pre3_ff.side  <= side2_ff;
      pre3_ff.mag_x <= ax2_ff;
      pre3_ff.mag_y <= ay2_ff;
      sqx3_ff  <= (2*COORD_W)'(ax2_ff) * (2*COORD_W)'(ax2_ff);
      sqy3_ff  <= (2*COORD_W)'(ay2_ff) * (2*COORD_W)'(ay2_ff);
      pre4_ff  <= pre3_ff;
      sum4_ff  <= {1'b0, sqx3_ff} + {1'b0, sqy3_ff};
   end

   sld_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v4_ff),
      .in_rad    (RAD_W'(sum4_ff)),
      .out_valid (root_valid),
      .out_root  (root)
   );

   // hold the sideband alongside the root stages
   always_ff @(posedge clock) begin
      pre_dly_ff[0] <= pre4_ff;
      for (int k = 1; k < SQRT_STAGES; k++) begin
         pre_dly_ff[k] <= pre_dly_ff[k-1];
      end
   end

   sld_div u_div_x (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (root_valid),
      .in_mag    (pre_dly_ff[SQRT_STAGES-1].mag_x),
      .in_len    (root),
      .out_valid (qx_valid),
      .out_quot  (qx)
   );

   sld_div u_div_y (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (root_valid),
      .in_mag    (pre_dly_ff[SQRT_STAGES-1].mag_y),
      .in_len    (root),
      .out_valid (qy_valid),
      .out_quot  (qy)
   );

   assign post_in.side = pre_dly_ff[SQRT_STAGES-1].side;
   assign post_in.len  = root;

   // hold the sideband and length alongside the quotient stages
   always_ff @(posedge clock) begin
      post_dly_ff[0] <= post_in;
      for (int k = 1; k < DIV_STAGES; k++) begin
         post_dly_ff[k] <= post_dly_ff[k-1];
      end
   end

   // apply signs; drop the quotient when the length is zero
   always_comb begin
      sld_post_type p;
      logic [DIR_W-1:0] mx, my;
      p  = post_dly_ff[DIV_STAGES-1];
      mx = {1'b0, qx};
      my = {1'b0, qy};
      rsp_in.start_x     = p.side.start_x;
      rsp_in.start_y     = p.side.start_y;
      rsp_in.end_x       = p.side.end_x;
      rsp_in.end_y       = p.side.end_y;
      rsp_in.mid_z       = p.side.mid_z;
      rsp_in.length      = p.len;
      rsp_in.zero_length = (p.len == '0);
      if (p.len == '0) begin
         rsp_in.dir_x = '0;
         rsp_in.dir_y = '0;
      end else begin
         rsp_in.dir_x = p.side.neg_x ? -mx : mx;
         rsp_in.dir_y = p.side.neg_y ? -my : my;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= qx_valid & qy_valid;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_latency : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, PIPE_LATENCY))
      else $error("result without a transfer at the expected latency");

   a_lanes : assert property (@(posedge clock) disable iff (reset)
      qx_valid == qy_valid)
      else $error("divider lanes out of step");

   a_zero_dir : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.zero_length |->
         rsp_data.dir_x == '0 && rsp_data.dir_y == '0)
      else $error("zero length with nonzero direction");

   a_dir_bound : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.dir_x >= -16'sd16384 && rsp_data.dir_x <= 16'sd16384
                 && rsp_data.dir_y >= -16'sd16384 && rsp_data.dir_y <= 16'sd16384)
      else $error("direction component beyond unit range");

endmodule

/* test/segment_length_and_direction_tb.sv */
`timescale 1ns / 1ps

module segment_length_and_direction_tb;
   import sld_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   sld_req_type req_data = '0;
   logic        rsp_valid;
   sld_rsp_type rsp_data;

   segment_length_and_direction dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   sld_req_type pending_segments[$];
   sld_rsp_type expected_results[$];
   int unsigned mismatch_count = 0;
   int unsigned result_count = 0;
   int unsigned zero_length_count = 0;
   int unsigned segments_sent = 0;
   bit          stimulus_done = 1'b0;
   int          gap_left = 0;
   int unsigned idle_until = 0;

   // Floored integer square root, one root bit per pass.
   function automatic logic [LEN_W-1:0] floor_root(input logic [63:0] radicand);
      logic [63:0] root;
      logic [63:0] bit_val;
      root = 0;
      bit_val = 64'd1 << 62;
      while (bit_val > radicand) bit_val = bit_val >> 2;
      while (bit_val != 0) begin
         if (radicand >= root + bit_val) begin
            radicand = radicand - (root + bit_val);
            root = (root >> 1) + bit_val;
         end else begin
            root = root >> 1;
         end
         bit_val = bit_val >> 2;
      end
      return root[LEN_W-1:0];
   endfunction

   // Signed Q1.14 component, truncated toward zero.
   function automatic logic [DIR_W-1:0] unit_component(input longint delta,
                                                      input longint len);
      longint mag;
      longint quot;
      mag = (delta < 0) ? -delta : delta;
      quot = (mag << DIR_FRAC) / len;
      return (delta < 0) ? DIR_W'(-quot) : DIR_W'(quot);
   endfunction

   function automatic sld_rsp_type segment_geometry(input sld_req_type seg);
      sld_rsp_type r;
      longint ddx;
      longint ddy;
      longint zsum;
      longint len;
      ddx = longint'(seg.second_x) - longint'(seg.first_x);
      ddy = longint'(seg.second_y) - longint'(seg.first_y);
      zsum = longint'(seg.first_z) + longint'(seg.second_z);
      r.start_x = seg.first_x;
      r.start_y = seg.first_y;
      r.end_x = seg.second_x;
      r.end_y = seg.second_y;
      r.mid_z = COORD_W'(zsum >>> 1);
      len = floor_root(64'(ddx * ddx + ddy * ddy));
      r.length = LEN_W'(len);
      if (len == 0) begin
         r.dir_x = '0;
         r.dir_y = '0;
         r.zero_length = 1'b1;
      end else begin
         r.dir_x = unit_component(ddx, len);
         r.dir_y = unit_component(ddy, len);
         r.zero_length = 1'b0;
      end
      return r;
   endfunction

   function automatic logic [COORD_W-1:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return 24'h7FFFFF;
         1: return 24'h800000;
         2: return COORD_W'($urandom_range(0, 64)) - 24'd32;
         default: return COORD_W'($urandom);
      endcase
   endfunction

   task automatic add_segment(input logic [COORD_W-1:0] x1, y1, z1, x2, y2, z2);
      sld_req_type s;
      s.first_x = x1;
      s.first_y = y1;
      s.first_z = z1;
      s.second_x = x2;
      s.second_y = y2;
      s.second_z = z2;
      pending_segments.push_back(s);
   endtask

   // Fill the queue: directed corners first, then random segments.
   initial begin
      sld_req_type s;
      add_segment(0, 0, 0, 0, 0, 0);
      add_segment(24'h123456, 24'h800000, 24'h7FFFFF, 24'h123456, 24'h800000, 24'h7FFFFF);
      add_segment(24'h800000, 24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h800000);
      add_segment(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000, 24'h7FFFFF);
      add_segment(24'h800000, 0, 24'hFFFFFF, 24'h7FFFFF, 0, 0);
      add_segment(0, 24'h7FFFFF, 1, 0, 24'h800000, 0);
      add_segment(0, 0, 24'hFFFFFF, 1, 0, 24'hFFFFFE);
      add_segment(0, 0, 3, 0, 24'hFFFFFF, 0);
      add_segment(0, 0, 0, 3, 4, 0);
      add_segment(5, 5, 24'hFFFFFD, 2, 1, 0);
      add_segment(24'hFFFFFF, 24'hFFFFFF, 24'h555555, 0, 0, 24'hAAAAAA);
      add_segment(0, 0, 0, 24'h001000, 24'h001000, 0);
      add_segment(24'hAAAAAA, 24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA, 24'h555555);
      repeat (1700) begin
         s = sld_req_type'({$urandom, $urandom, $urandom, $urandom, $urandom});
         s.first_x = rand_coord();
         s.first_y = rand_coord();
         s.first_z = rand_coord();
         s.second_x = ($urandom_range(0, 9) == 0) ? s.first_x : rand_coord();
         s.second_y = ($urandom_range(0, 9) == 0) ? s.first_y : rand_coord();
         s.second_z = rand_coord();
         pending_segments.push_back(s);
      end
      idle_until = pending_segments.size() - 200;
   end

   // Driver: offer one segment per cycle while busy is low, with random idle bursts until late.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         // retire the transfer completed at this edge
         if (start && !busy) begin
            expected_results.push_back(segment_geometry(req_data));
            segments_sent++;
         end
         if (start && busy) begin
            // hold the offer
         end else if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_segments.size() > 0 && segments_sent < idle_until
                      && $urandom_range(0, 7) == 0) begin
            gap_left = $urandom_range(0, 5);
            start <= 1'b0;
         end else if (pending_segments.size() > 0) begin
            req_data <= pending_segments.pop_front();
            start <= 1'b1;
         end else begin
            start <= 1'b0;
            stimulus_done <= 1'b1;
         end
      end
   end

   // Monitor: each strobed result is compared with the oldest expectation.
   always @(posedge clock) begin
      sld_rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected result %h", rsp_data);
         end else begin
            want = expected_results.pop_front();
            result_count++;
            if (want.zero_length) zero_length_count++;
            if (rsp_data.start_x !== want.start_x || rsp_data.start_y !== want.start_y ||
                rsp_data.end_x !== want.end_x || rsp_data.end_y !== want.end_y ||
                rsp_data.mid_z !== want.mid_z || rsp_data.length !== want.length ||
                rsp_data.dir_x !== want.dir_x || rsp_data.dir_y !== want.dir_y ||
                rsp_data.zero_length !== want.zero_length) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected %h got %h", want, rsp_data);
            end
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      wait (stimulus_done && expected_results.size() == 0);
      repeat (PIPE_LATENCY + 10) @(posedge clock);
      $display("checked %0d segments, %0d of zero length", result_count,
               zero_length_count);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Abort a hung run.
   initial begin
      #2000000;
      $display("timeout");
      $display("*** FAILED ***");
      $finish;
   end

endmodule
